@@ hw/rtl/ffba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int DefMaxBlocks  = 64;
  localparam int DefHeaderBytes = 32;
  localparam logic [26:0] MaxRequestReset = 27'd100000000;

  // configuration register indexes
  localparam logic [1:0] RegHeapBase   = 2'd0;
  localparam logic [1:0] RegHeapLimit  = 2'd1;
  localparam logic [1:0] RegMaxRequest = 2'd2;

  // request types
  localparam logic [1:0] ReqAlloc  = 2'd0;
  localparam logic [1:0] ReqZalloc = 2'd1;
  localparam logic [1:0] ReqFree   = 2'd2;
  localparam logic [1:0] ReqResize = 2'd3;

  // status codes
  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StSizeBad   = 2'd1;
  localparam logic [1:0] StExhausted = 2'd2;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]  kind;
    logic        size_bad;
    logic [26:0] size;
    logic [31:0] addr;
  } cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/ffba_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_front
// Accepts requests, checks sizes and forms the zeroed-allocate product in a
// separate multiply state (27x27 cut into a 27x14 and a 27x13 partial product).
// ----------------------------------------------------------------------------
module ffba_front import ffba_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [26:0] max_request,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [26:0] req_size,
  input  wire logic [26:0] req_count,
  input  wire logic [31:0] block_addr,
  output logic             cmd_valid,
  input  wire logic        cmd_ready,
  output cmd_t             cmd
);

  typedef enum logic [1:0] {S_IDLE, S_MUL_HI, S_CHECK, S_OUT} state_t;
  state_t state;

  logic [1:0]  kind;
  logic [26:0] size, count;
  logic [31:0] addr;
  logic [53:0] prod;
  logic [40:0] part_lo;

  assign in_ready  = (state == S_IDLE);
  assign cmd_valid = (state == S_OUT);

  // hold state, product and output command
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind  <= req_type;
            size  <= req_size;
            count <= req_count;
            addr  <= block_addr;
            state <= (req_type == ReqZalloc) ? S_MUL_HI : S_CHECK;
          end
        end
        S_MUL_HI: begin
          part_lo <= size * count[13:0];
          prod    <= {27'd0, size} * {41'd0, count[26:14]};
          state   <= S_CHECK;
        end
        S_CHECK: begin
          cmd.kind <= kind;
          cmd.addr <= addr;
          if (kind == ReqZalloc) begin
            cmd.size_bad <= (size == 27'd0) || (size > max_request) ||
                            (count == 27'd0) || (count > max_request) ||
                            (((prod << 14) + {13'd0, part_lo}) >
                             {27'd0, max_request});
            cmd.size <= part_lo[26:0] + {prod[12:0], 14'd0};
          end else begin
            cmd.size_bad <= (size == 27'd0) || (size > max_request);
            cmd.size     <= size;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (cmd_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ffba_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module ffba_queue import ffba_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  wire cmd_t wr_data,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output cmd_t      rd_data
);

  cmd_t       mem [2];
  logic       wp, rp;
  logic [1:0] fill;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = mem[rp];

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; fill <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) begin
        mem[wp] <= wr_data;
        wp <= ~wp;
      end
      if (rd_valid && rd_ready) rp <= ~rp;
      fill <= fill + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ffba_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_back
// Block table and sequencer: scans the table one entry at a time for lookup
// and first fit, then appends, releases and updates counters.
// ----------------------------------------------------------------------------
module ffba_back import ffba_pkg::*; #(
  parameter int MAX_BLOCKS   = DefMaxBlocks,
  parameter int HEADER_BYTES = DefHeaderBytes
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [31:0] cfg_data,
  input  wire logic [31:0] heap_limit,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire cmd_t        cmd,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      result_addr,
  output logic [1:0]       status,
  output logic [31:0]      move_src,
  output logic [26:0]      move_len,
  output logic [26:0]      zero_len,
  output logic [6:0]       free_blocks,
  output logic [31:0]      free_bytes,
  output logic [6:0]       allocated_blocks,
  output logic [31:0]      allocated_bytes
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [31:0] Hdr = 32'(HEADER_BYTES);
  localparam logic [CW-1:0] Full = CW'(MAX_BLOCKS);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_FIND_CHK, S_FIT, S_FIT_CHK, S_GROW, S_REL, S_DONE
  } state_t;
  state_t state;

  // block table memory: start and size; free marks in flip-flops
  logic [31:0] tab_start [MAX_BLOCKS];
  logic [26:0] tab_size  [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] tab_free;
  logic [31:0] rd_start;
  logic [26:0] rd_size;
  logic [IW-1:0] rd_idx;
  logic        wr_en;
  logic [IW-1:0] wr_idx;

  logic [CW-1:0] bcount, scan;
  logic [31:0] heap_top, fbytes, tbytes;
  logic [6:0]  fblocks;
  cmd_t        c;
  logic        found;
  logic [IW-1:0] fidx;
  logic [26:0] fsize;
  logic [32:0] grow_end;

  // take a new request only once the previous result has left
  assign cmd_ready = (state == S_IDLE) && !out_valid;
  assign free_blocks      = fblocks;
  assign free_bytes       = fbytes;
  assign allocated_blocks = 7'(bcount);
  assign allocated_bytes  = tbytes;
  assign grow_end = {1'b0, heap_top} + {1'b0, Hdr} + {6'd0, c.size};

  // table write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tab_start[wr_idx] <= heap_top;
      tab_size[wr_idx]  <= c.size;
    end
    rd_start <= tab_start[rd_idx];
    rd_size  <= tab_size[rd_idx];
  end

  assign rd_idx = scan[IW-1:0];
  assign wr_en  = (state == S_GROW) && (bcount != Full) && !grow_end[32] &&
                  (grow_end[31:0] <= heap_limit);
  assign wr_idx = bcount[IW-1:0];

  // sequence each command and hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_valid <= 1'b0;
      tab_free <= '0;
      bcount   <= '0;
      heap_top <= 32'd0;
      fblocks  <= 7'd0;
      fbytes   <= 32'd0;
      tbytes   <= 32'd0;
    end else begin
      if (state == S_DONE) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_we && cfg_idx == RegHeapBase && bcount == '0) heap_top <= cfg_data;
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            c <= cmd;
            scan <= '0;
            found <= 1'b0;
            result_addr <= 32'd0; status <= StOk;
            move_src <= 32'd0; move_len <= 27'd0; zero_len <= 27'd0;
            if (cmd.kind == ReqFree) state <= (cmd.addr == 32'd0) ? S_DONE : S_FIND;
            else if (cmd.size_bad) begin
              status <= StSizeBad; state <= S_DONE;
            end else if (cmd.kind == ReqResize && cmd.addr != 32'd0) state <= S_FIND;
            else state <= S_FIT;
          end
        end
        // address lookup: issue read
        S_FIND: begin
          if (scan >= bcount) begin
            found <= 1'b0;
            state <= (c.kind == ReqFree) ? S_DONE : S_FIT;
            scan <= '0;
          end else state <= S_FIND_CHK;
        end
        S_FIND_CHK: begin
          if (rd_start + Hdr == c.addr) begin
            found <= 1'b1; fidx <= scan[IW-1:0]; fsize <= rd_size;
            if (c.kind == ReqFree) begin
              if (!tab_free[scan[IW-1:0]]) begin
                tab_free[scan[IW-1:0]] <= 1'b1;
                fblocks <= fblocks + 7'd1;
                fbytes  <= fbytes + {5'd0, rd_size};
              end
              state <= S_DONE;
            end else if (c.size <= rd_size) begin
              result_addr <= c.addr; state <= S_DONE;
            end else begin
              scan <= '0; state <= S_FIT;
            end
          end else begin
            scan <= scan + CW'(1); state <= S_FIND;
          end
        end
        // first fit over free blocks
        S_FIT: begin
          if (scan >= bcount) state <= S_GROW;
          else state <= S_FIT_CHK;
        end
        S_FIT_CHK: begin
          if (tab_free[scan[IW-1:0]] && c.size <= rd_size) begin
            tab_free[scan[IW-1:0]] <= 1'b0;
            fblocks <= fblocks - 7'd1;
            fbytes  <= fbytes - {5'd0, rd_size};
            result_addr <= rd_start + Hdr;
            if (c.kind == ReqZalloc) zero_len <= c.size;
            state <= found ? S_REL : S_DONE;
          end else begin
            scan <= scan + CW'(1); state <= S_FIT;
          end
        end
        S_GROW: begin
          if (wr_en) begin
            tab_free[wr_idx] <= 1'b0;
            bcount <= bcount + CW'(1);
            result_addr <= heap_top + Hdr;
            heap_top <= grow_end[31:0];
            tbytes <= tbytes + {5'd0, c.size};
            if (c.kind == ReqZalloc) zero_len <= c.size;
            state <= found ? S_REL : S_DONE;
          end else begin
            status <= StExhausted; state <= S_DONE;
          end
        end
        // release old block after a resize move
        S_REL: begin
          move_src <= c.addr; move_len <= fsize;
          if (!tab_free[fidx]) begin
            tab_free[fidx] <= 1'b1;
            fblocks <= fblocks + 7'd1;
            fbytes  <= fbytes + {5'd0, fsize};
          end
          state <= S_DONE;
        end
        // raise the result (done above) and return to idle
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/first_fit_block_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap block allocator without splitting; table of blocks in
// address order, append at heap top when nothing fits.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  request   in_valid / in_ready       req_type req_size req_count block_addr
//  result    out_valid / out_ready     result_addr status move_src ... counts
//  config    cfg_we                    cfg_idx cfg_data
//
// The back scans the table entries one at a time, with a read state and a
// check state per entry; a resize may look up and then search a full table.
// The front registers a request, checks it and then offers it, with an extra
// multiply step for a zeroed allocate; it takes no new request until the last
// is handed on, and overlaps the back through a two-entry queue. Reset is
// synchronous; no clearing pass is needed. A stalled result holds the back.
// ----------------------------------------------------------------------------
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int MAX_BLOCKS   = DefMaxBlocks,
  parameter int HEADER_BYTES = DefHeaderBytes
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [26:0] req_size,
  input  wire logic [26:0] req_count,
  input  wire logic [31:0] block_addr,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      result_addr,
  output logic [1:0]       status,
  output logic [31:0]      move_src,
  output logic [26:0]      move_len,
  output logic [26:0]      zero_len,
  output logic [6:0]       free_blocks,
  output logic [31:0]      free_bytes,
  output logic [6:0]       allocated_blocks,
  output logic [31:0]      allocated_bytes
);

  logic [31:0] heap_limit;
  logic [26:0] max_request;
  logic f_valid, f_ready, q_valid, q_ready;
  cmd_t f_cmd, q_cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit  <= 32'hFFFF_FFFF;
      max_request <= MaxRequestReset;
    end else if (cfg_we) begin
      if (cfg_idx == RegHeapLimit)  heap_limit  <= cfg_data;
      if (cfg_idx == RegMaxRequest) max_request <= cfg_data[26:0];
    end
  end

  ffba_front u_front (
    .clk, .rst, .max_request, .in_valid, .in_ready,
    .req_type, .req_size, .req_count, .block_addr,
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  ffba_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  ffba_back #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)) u_back (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data, .heap_limit,
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_valid, .out_ready, .result_addr, .status, .move_src, .move_len,
    .zero_len, .free_blocks, .free_bytes, .allocated_blocks, .allocated_bytes
  );

  // failed requests grant no address
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != StOk |-> result_addr == 32'd0)
    else $error("failed request returned an address");

  // free blocks never exceed created blocks
  assert property (@(posedge clk) disable iff (rst)
    free_blocks <= allocated_blocks)
    else $error("free block count above block count");

  // a move is reported only with a granted address
  assert property (@(posedge clk) disable iff (rst)
    out_valid && move_len != 27'd0 |-> status == StOk && move_src != 32'd0)
    else $error("move without grant");

endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for first_fit_block_allocator. Requests are driven over the
// valid/ready channel and each one is also applied to a table model inside a
// scoreboard. That model produces the expected result. Results are compared
// field by field, in order, as they leave the block. The run starts with
// directed cases, then random traffic under several heap settings, with
// random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import ffba_pkg::*;

  localparam int NumBlocks = 64;
  localparam int HdrBytes  = 32;

  typedef struct {
    logic [31:0] result_addr;
    logic [1:0]  status;
    logic [31:0] move_src;
    logic [26:0] move_len;
    logic [26:0] zero_len;
    logic [6:0]  free_blocks;
    logic [31:0] free_bytes;
    logic [6:0]  allocated_blocks;
    logic [31:0] allocated_bytes;
  } alloc_result_t;

  // Tracks the block table and counters, and holds the expected responses.
  class alloc_scoreboard;
    logic [31:0] heap_base, heap_limit, heap_top;
    logic [26:0] max_request;
    logic [31:0] blk_start [NumBlocks];
    logic [26:0] blk_size [NumBlocks];
    bit          blk_free [NumBlocks];
    int          blk_count;
    logic [6:0]  free_cnt;
    logic [31:0] free_byte_cnt, total_byte_cnt;
    alloc_result_t pending_q[$];
    int errors, checked, moves, fails;

    function new();
      heap_base = 0; heap_limit = 32'hFFFF_FFFF; max_request = MaxRequestReset;
      heap_top = 0; blk_count = 0; free_cnt = 0; free_byte_cnt = 0;
      total_byte_cnt = 0; errors = 0; checked = 0; moves = 0; fails = 0;
      foreach (blk_free[i]) blk_free[i] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        RegHeapBase: begin
          heap_base = data;
          if (blk_count == 0) heap_top = data;
        end
        RegHeapLimit: heap_limit = data;
        RegMaxRequest: max_request = data[26:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // payload address of a random existing block, or zero when none exists
    function logic [31:0] random_payload();
      if (blk_count == 0) return 32'd0;
      return blk_start[$urandom_range(0, blk_count - 1)] + HdrBytes;
    endfunction

    function int lookup(logic [31:0] payload);
      for (int i = 0; i < blk_count; i++)
        if (blk_start[i] + HdrBytes == payload) return i;
      return -1;
    endfunction

    // first fit over free blocks, else append at the heap top
    function logic [1:0] take(logic [26:0] size, output logic [31:0] addr);
      logic [63:0] blk_end;
      addr = 0;
      for (int i = 0; i < blk_count; i++) begin
        if (blk_free[i] && size <= blk_size[i]) begin
          blk_free[i] = 0;
          free_cnt = free_cnt - 1;
          free_byte_cnt = free_byte_cnt - blk_size[i];
          addr = blk_start[i] + HdrBytes;
          return StOk;
        end
      end
      if (blk_count >= NumBlocks) return StExhausted;
      blk_end = {32'd0, heap_top} + HdrBytes + size;
      if (blk_end > {32'd0, heap_limit}) return StExhausted;
      blk_start[blk_count] = heap_top;
      blk_size[blk_count] = size;
      blk_free[blk_count] = 0;
      blk_count++;
      addr = heap_top + HdrBytes;
      heap_top = blk_end[31:0];
      total_byte_cnt = total_byte_cnt + size;
      return StOk;
    endfunction

    function void release_payload(logic [31:0] payload);
      int k;
      if (payload == 0) return;
      k = lookup(payload);
      if (k < 0 || blk_free[k]) return;
      blk_free[k] = 1;
      free_cnt = free_cnt + 1;
      free_byte_cnt = free_byte_cnt + blk_size[k];
    endfunction

    // apply an accepted request and queue its expected response
    function void note_request(logic [1:0] kind, logic [26:0] size,
                               logic [26:0] count, logic [31:0] addr);
      alloc_result_t r;
      logic [53:0] prod;
      logic [26:0] prior_len;
      bit size_bad;
      int k;
      r = '{default: 0};
      size_bad = (size == 0 || size > max_request);
      case (kind)
        ReqAlloc: begin
          if (size_bad) r.status = StSizeBad;
          else r.status = take(size, r.result_addr);
        end
        ReqZalloc: begin
          prod = size * count;
          if (size_bad || count == 0 || count > max_request || prod > max_request)
            r.status = StSizeBad;
          else begin
            r.status = take(prod[26:0], r.result_addr);
            if (r.status == StOk) r.zero_len = prod[26:0];
          end
        end
        ReqFree: release_payload(addr);
        default: begin
          k = (addr == 0) ? -1 : lookup(addr);
          if (size_bad) r.status = StSizeBad;
          else if (k < 0) r.status = take(size, r.result_addr);
          else if (size <= blk_size[k]) r.result_addr = addr;
          else begin
            prior_len = blk_size[k];
            r.status = take(size, r.result_addr);
            if (r.status == StOk) begin
              r.move_src = addr;
              r.move_len = prior_len;
              release_payload(addr);
              moves++;
            end
          end
        end
      endcase
      if (r.status != StOk) fails++;
      r.free_blocks = free_cnt;
      r.free_bytes = free_byte_cnt;
      r.allocated_blocks = blk_count[6:0];
      r.allocated_bytes = total_byte_cnt;
      pending_q.push_back(r);
    endfunction

    function void cmp(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none, actual addr %0h",
                 $time, got.result_addr);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      cmp("result_addr", want.result_addr, got.result_addr);
      cmp("status", want.status, got.status);
      cmp("move_src", want.move_src, got.move_src);
      cmp("move_len", want.move_len, got.move_len);
      cmp("zero_len", want.zero_len, got.zero_len);
      cmp("free_blocks", want.free_blocks, got.free_blocks);
      cmp("free_bytes", want.free_bytes, got.free_bytes);
      cmp("allocated_blocks", want.allocated_blocks, got.allocated_blocks);
      cmp("allocated_bytes", want.allocated_bytes, got.allocated_bytes);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_idx = 0;
  logic [31:0] cfg_data = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  req_type = 0;
  logic [26:0] req_size = 0;
  logic [26:0] req_count = 0;
  logic [31:0] block_addr = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] result_addr, move_src, free_bytes, allocated_bytes;
  logic [1:0]  status;
  logic [26:0] move_len, zero_len;
  logic [6:0]  free_blocks, allocated_blocks;

  alloc_scoreboard sb = new();
  bit idle_on = 1;
  int rx_hold = 0;
  int sent = 0;

  first_fit_block_allocator u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
    .req_size(req_size), .req_count(req_count), .block_addr(block_addr),
    .out_valid(out_valid), .out_ready(out_ready), .result_addr(result_addr),
    .status(status), .move_src(move_src), .move_len(move_len),
    .zero_len(zero_len), .free_blocks(free_blocks), .free_bytes(free_bytes),
    .allocated_blocks(allocated_blocks), .allocated_bytes(allocated_bytes)
  );

  always #5 clk = ~clk;

  // receiver: random stall bursts, plus a long hold when asked
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ready <= 0;
        rx_hold--;
      end else begin
        if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, 12);
        if (stall_left > 0) begin
          out_ready <= 0;
          stall_left--;
        end else out_ready <= 1;
      end
    end
  end

  // check each response as it is taken
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{result_addr, status, move_src, move_len, zero_len,
                        free_blocks, free_bytes, allocated_blocks, allocated_bytes});
  end

  // issue one request and hold it until accepted
  task automatic send(logic [1:0] kind, logic [26:0] size, logic [26:0] count,
                      logic [31:0] addr);
    int gap;
    gap = 0;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    req_type <= kind;
    req_size <= size;
    req_count <= count;
    block_addr <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(kind, size, count, addr);
    sent++;
  endtask

  // drop valid and wait for every outstanding response
  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, data);
  endtask

  // random request: mostly sane traffic on live blocks, some noise
  task automatic send_random();
    int sel;
    logic [26:0] size, count;
    logic [31:0] addr;
    sel = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0: size = $urandom_range(0, 27'h7FF_FFFF);
      1: size = $urandom_range(1, sb.max_request);
      2: size = 0;
      default: size = $urandom_range(1, 256);
    endcase
    count = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 27'h7FF_FFFF)
                                        : $urandom_range(1, 16);
    case ($urandom_range(0, 9))
      0: addr = 0;
      1: addr = $urandom;
      default: addr = sb.random_payload();
    endcase
    if (sel < 35) send(ReqAlloc, size, count, addr);
    else if (sel < 45) begin
      if ($urandom_range(0, 3) != 0) size = $urandom_range(1, 32);
      send(ReqZalloc, size, count, addr);
    end else if (sel < 75) send(ReqFree, size, count, addr);
    else if (sel < 95) send(ReqResize, size, count, addr);
    else send($urandom_range(0, 3), $urandom, $urandom, $urandom);
  endtask

  task automatic random_phase(int n, int hold_at, int pause_at, int quiet_from);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) rx_hold = 400;
      if (i == pause_at) begin
        @(negedge clk);
        in_valid <= 0;
        while (sb.pending() != 0) @(posedge clk);
      end
      if (i == quiet_from) idle_on = 0;
      send_random();
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // small heap so growth failure is reachable
    write_reg(RegHeapBase, 32'd0);
    write_reg(RegHeapBase, 32'h0000_1000);
    write_reg(RegHeapLimit, 32'h0000_1400);
    write_reg(RegMaxRequest, 27'h7FF_FFFF);

    send(ReqAlloc, 0, 0, 0);
    send(ReqAlloc, 27'h7FF_FFFF, 0, 0);
    send(ReqAlloc, 64, 0, 0);
    send(ReqZalloc, 16, 0, 0);
    send(ReqZalloc, 27'h7FF_FFFF, 27'h7FF_FFFF, 0);
    send(ReqZalloc, 16, 8, 0);
    send(ReqFree, 0, 0, 0);
    send(ReqFree, 0, 0, 32'hFFFF_FFFF);
    send(ReqFree, 0, 0, 32'h0000_1020);
    send(ReqFree, 0, 0, 32'h0000_1020);
    send(ReqAlloc, 32, 0, 0);
    send(ReqResize, 16, 0, 0);
    send(ReqResize, 8, 0, 32'h1234_5678);
    send(ReqResize, 1, 0, sb.blk_start[1] + HdrBytes);
    send(ReqResize, 100, 0, sb.blk_start[2] + HdrBytes);
    send(ReqResize, 4, 0, sb.blk_start[2] + HdrBytes);
    send(ReqResize, 0, 0, sb.blk_start[0] + HdrBytes);
    send(ReqAlloc, 2000, 0, 0);
    drain();

    // smallest size limit
    write_reg(RegHeapLimit, 32'hFFFF_FFFF);
    write_reg(RegMaxRequest, 27'd1);
    send(ReqAlloc, 1, 0, 0);
    send(ReqAlloc, 2, 0, 0);
    send(ReqZalloc, 1, 1, 0);
    send(ReqResize, 27'h7FF_FFFF, 0, 0);
    drain();

    write_reg(RegMaxRequest, 27'd100000000);
    random_phase(500, 100, 300, -1);

    // base write is ignored once blocks exist
    write_reg(RegHeapBase, 32'hFFFF_FFFF);
    write_reg(RegHeapLimit, 32'h8000_0000);
    write_reg(RegMaxRequest, 27'd4096);
    random_phase(500, -1, -1, -1);

    write_reg(RegHeapLimit, 32'hFFFF_FFFF);
    write_reg(RegMaxRequest, 27'h7FF_FFFF);
    random_phase(520, -1, -1, 220);

    repeat (300) @(posedge clk);
    $display("Covered %0d requests, %0d responses checked, %0d resize moves,",
             sent, sb.checked, sb.moves);
    $display("%0d failed requests, %0d blocks in table at the end.",
             sb.fails, sb.blk_count);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d responses outstanding", sb.pending());
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_front.sv
hw/rtl/ffba_queue.sv
hw/rtl/ffba_back.sv
hw/rtl/first_fit_block_allocator.sv
bench/tb.sv
